>>> hdl/bmalloc_pkg.sv
// Shared types and constants for the bitmap allocator.
// Holds sizing, command and status codes, the sequencer states and the range record.
// No dependencies.
package bmalloc_pkg;

    localparam int WORD_COUNT    = 16;
    localparam int BITS_PER_WORD = 64;
    localparam int POS_W         = 6;
    localparam int CAPACITY      = WORD_COUNT * BITS_PER_WORD;
    localparam int ADDR_W        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int LEN_W         = $clog2(WORD_COUNT + 1);
    localparam int ITEM_W        = 32;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 8;
    localparam int BYTE_W        = 8;
    localparam int BYTE_CNT      = BITS_PER_WORD / BYTE_W;
    localparam int BYTE_IDX_W    = 3;
    localparam int BIT_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ITEM  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ITEM = CFG_IDX_W'(1);

    localparam logic [ITEM_W-1:0] LOW_ITEM_RESET  = ITEM_W'(0);
    localparam logic [ITEM_W-1:0] HIGH_ITEM_RESET = ITEM_W'(1023);

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_FIND  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_BIT,
        S_SCAN,
        S_LOCATE,
        S_POS,
        S_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              settled;
        logic              empty;
        logic [ITEM_W-1:0] low;
        logic [ITEM_W-1:0] top;
        logic [LEN_W-1:0]  len;
    } range_info_t;

endpackage

>>> hdl/bmalloc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Sized by WIDTH and DEPTH; no package dependency.
module bmalloc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/bmalloc_range.sv
// Derives the clamped top item and the number of words in use from the configuration.
// Two register stages, with a settle count after each configuration write.
// Depends on bmalloc_pkg.
module bmalloc_range (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bmalloc_pkg::ITEM_W-1:0]   low_item,
    input  logic [bmalloc_pkg::ITEM_W-1:0]   high_item,
    output bmalloc_pkg::range_info_t         rinfo
);
    import bmalloc_pkg::*;

    logic [ITEM_W:0]   diff;
    logic [ITEM_W-1:0] span_next;
    logic [ITEM_W-1:0] span_reg;
    logic              empty_reg;
    logic [ITEM_W-1:0] top_reg;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  len_reg;
    logic              empty2_reg;
    logic [1:0]        settle_reg;
    logic [1:0]        settle_next;

    assign diff = {1'b0, high_item} - {1'b0, low_item};

    always_comb begin
        if (diff[ITEM_W-1:0] > ITEM_W'(CAPACITY - 1)) begin
            span_next = ITEM_W'(CAPACITY - 1);
        end else begin
            span_next = diff[ITEM_W-1:0];
        end
        if (empty_reg) begin
            len_next = '0;
        end else begin
            len_next = LEN_W'(span_reg >> POS_W) + LEN_W'(1);
        end
        if (cfg_we) begin
            settle_next = 2'd2;
        end else if (settle_reg != 2'd0) begin
            settle_next = settle_reg - 2'd1;
        end else begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        span_reg   <= span_next;
        empty_reg  <= diff[ITEM_W];
        top_reg    <= low_item + span_reg;
        len_reg    <= len_next;
        empty2_reg <= empty_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= 2'd2;
        end else begin
            settle_reg <= settle_next;
        end
    end

    assign rinfo.settled = (settle_reg == 2'd0) && !cfg_we;
    assign rinfo.empty   = empty2_reg;
    assign rinfo.low     = low_item;
    assign rinfo.top     = top_reg;
    assign rinfo.len     = len_reg;

endmodule

>>> hdl/bmalloc_ctrl.sv
// Command sequencer: bit access, word scan from the cursor and first-free search.
// Owns the bitmap RAM, its per-word valid flags and the result register.
// Depends on bmalloc_pkg and bmalloc_ram.
module bmalloc_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bmalloc_pkg::range_info_t         rinfo,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bmalloc_pkg::CMD_W-1:0]    s_cmd,
    input  logic [bmalloc_pkg::ITEM_W-1:0]   s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bmalloc_pkg::STATUS_W-1:0] m_status,
    output logic                             m_bit_value,
    output logic [bmalloc_pkg::ITEM_W-1:0]   m_free_item
);
    import bmalloc_pkg::*;

    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [ITEM_W-1:0]        item_reg, item_next;
    logic [LEN_W-1:0]         cursor_reg, cursor_next;
    logic [WORD_COUNT-1:0]    valid_reg, valid_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [ADDR_W-1:0]        waddr_reg, waddr_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [BITS_PER_WORD-1:0] free_bits_reg, free_bits_next;
    logic [BYTE_IDX_W-1:0]    byte_idx_reg, byte_idx_next;
    logic [BYTE_W-1:0]        byte_reg, byte_next;
    logic [ITEM_W:0]          cand_reg, cand_next;
    status_t                  res_status_reg, res_status_next;
    logic                     res_bit_reg, res_bit_next;
    logic [ITEM_W-1:0]        res_free_reg, res_free_next;
    logic                     m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]      m_status_reg, m_status_next;
    logic                     m_bit_reg, m_bit_next;
    logic [ITEM_W-1:0]        m_free_reg, m_free_next;

    logic                     ram_rd_en;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic                     ram_wr_en;
    logic [BITS_PER_WORD-1:0] ram_wr_data;
    logic [BITS_PER_WORD-1:0] ram_rd_data;
    logic [BITS_PER_WORD-1:0] rd_word;

    logic [ITEM_W-1:0]        offset;
    logic                     in_range;
    logic                     cursor_past;
    logic                     word_full;
    logic [LEN_W-1:0]         cursor_inc;
    logic                     scan_end;
    logic                     out_free;
    logic                     accept;
    logic [BYTE_IDX_W-1:0]    first_byte;
    logic [BIT_IDX_W-1:0]     first_bit;

    bmalloc_ram #(
        .WIDTH (BITS_PER_WORD),
        .DEPTH (WORD_COUNT)
    ) u_bitmap_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (waddr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        rd_word     = rd_valid_reg ? ram_rd_data : '0;
        offset      = item_reg - rinfo.low;
        in_range    = !rinfo.empty && (item_reg >= rinfo.low) && (item_reg <= rinfo.top);
        cursor_past = (cursor_reg >= rinfo.len);
        word_full   = &rd_word;
        cursor_inc  = cursor_reg + LEN_W'(1);
        scan_end    = (cursor_inc >= rinfo.len);
        out_free    = !m_valid_reg || m_ready;
        accept      = s_valid && s_ready;
        first_byte  = '0;
        for (int i = BYTE_CNT - 1; i >= 0; i--) begin
            if (|free_bits_reg[i*BYTE_W +: BYTE_W]) begin
                first_byte = BYTE_IDX_W'(i);
            end
        end
        first_bit = '0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (byte_reg[i]) begin
                first_bit = BIT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (cmd_reg == CMD_FIND) begin
                    state_next = cursor_past ? S_DONE : S_SCAN;
                end else begin
                    state_next = in_range ? S_BIT : S_DONE;
                end
            end
            S_BIT: begin
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (!word_full) begin
                    state_next = S_LOCATE;
                end else if (scan_end) begin
                    state_next = S_DONE;
                end
            end
            S_LOCATE: begin
                state_next = S_POS;
            end
            S_POS: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        ram_wr_en       = 1'b0;
        ram_wr_data     = rd_word;
        cmd_next        = cmd_reg;
        item_next       = item_reg;
        cursor_next     = cursor_reg;
        valid_next      = valid_reg;
        rd_valid_next   = rd_valid_reg;
        waddr_next      = waddr_reg;
        pos_next        = pos_reg;
        free_bits_next  = free_bits_reg;
        byte_idx_next   = byte_idx_reg;
        byte_next       = byte_reg;
        cand_next       = cand_reg;
        res_status_next = res_status_reg;
        res_bit_next    = res_bit_reg;
        res_free_next   = res_free_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_bit_next      = m_bit_reg;
        m_free_next     = m_free_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = rinfo.settled;
                if (accept) begin
                    cmd_next        = cmd_t'(s_cmd);
                    item_next       = s_item;
                    res_status_next = STATUS_OK;
                    res_bit_next    = 1'b0;
                    res_free_next   = '0;
                end
            end
            S_DECODE: begin
                if (cmd_reg == CMD_FIND) begin
                    if (cursor_past) begin
                        cursor_next     = rinfo.len;
                        res_status_next = STATUS_FULL;
                    end else begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = cursor_reg[ADDR_W-1:0];
                        rd_valid_next = valid_reg[cursor_reg[ADDR_W-1:0]];
                    end
                end else if (in_range) begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = offset[POS_W +: ADDR_W];
                    rd_valid_next = valid_reg[offset[POS_W +: ADDR_W]];
                    waddr_next    = offset[POS_W +: ADDR_W];
                    pos_next      = offset[POS_W-1:0];
                end else if (cmd_reg == CMD_READ) begin
                    res_status_next = STATUS_RANGE;
                end
            end
            S_BIT: begin
                priority case (cmd_reg)
                    CMD_SET: begin
                        ram_wr_en              = 1'b1;
                        ram_wr_data[pos_reg]   = 1'b1;
                        valid_next[waddr_reg]  = 1'b1;
                    end
                    CMD_CLEAR: begin
                        ram_wr_en              = 1'b1;
                        ram_wr_data[pos_reg]   = 1'b0;
                        valid_next[waddr_reg]  = 1'b1;
                    end
                    default: begin
                        res_bit_next = rd_word[pos_reg];
                    end
                endcase
            end
            S_SCAN: begin
                if (!word_full) begin
                    free_bits_next = ~rd_word;
                end else begin
                    cursor_next = cursor_inc;
                    if (scan_end) begin
                        res_status_next = STATUS_FULL;
                    end else begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = cursor_inc[ADDR_W-1:0];
                        rd_valid_next = valid_reg[cursor_inc[ADDR_W-1:0]];
                    end
                end
            end
            S_LOCATE: begin
                byte_idx_next = first_byte;
                byte_next     = free_bits_reg[first_byte*BYTE_W +: BYTE_W];
            end
            S_POS: begin
                cand_next = {{(ITEM_W + 1 - LEN_W - POS_W){1'b0}}, cursor_reg, {POS_W{1'b0}}}
                          + {1'b0, rinfo.low}
                          + (ITEM_W + 1)'({byte_idx_reg, first_bit});
            end
            S_CHECK: begin
                if (cand_reg > {1'b0, rinfo.top}) begin
                    res_status_next = STATUS_FULL;
                end else begin
                    res_free_next = cand_reg[ITEM_W-1:0];
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_bit_next    = res_bit_reg;
                    m_free_next   = res_free_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cursor_reg  <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        item_reg       <= item_next;
        rd_valid_reg   <= rd_valid_next;
        waddr_reg      <= waddr_next;
        pos_reg        <= pos_next;
        free_bits_reg  <= free_bits_next;
        byte_idx_reg   <= byte_idx_next;
        byte_reg       <= byte_next;
        cand_reg       <= cand_next;
        res_status_reg <= res_status_next;
        res_bit_reg    <= res_bit_next;
        res_free_reg   <= res_free_next;
        m_status_reg   <= m_status_next;
        m_bit_reg      <= m_bit_next;
        m_free_reg     <= m_free_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_bit_value = m_bit_reg;
    assign m_free_item = m_free_reg;

endmodule

>>> hdl/bitmap_allocator_find_free_top.sv
// Top level of the bitmap allocator: configuration registers, range unit and sequencer.
// Depends on bmalloc_pkg, bmalloc_range and bmalloc_ctrl.
//
//   Channel   Direction   Handshake              Word
//   s_        in          s_valid / s_ready      s_cmd, s_item
//   m_        out         m_valid / m_ready      m_status, m_bit_value, m_free_item
//   cfg_      in          cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Read, set and clear pass decode and bit access before the result word, and skip the
// bit access when the item is out of range. A find passes decode, scan, locate, position
// and check; the scan holds while it skips full words, since it reads one bitmap word per
// cycle from the single RAM read port. A find that starts past the last word in use goes
// from decode to the result, and one that skips full words up to the end goes from the scan to the result.
// The bitmap needs no clearing pass after reset: per-word valid flags make unwritten
// words read as free. The input is held off after reset, and from a configuration write
// until the settle count runs out, while the range is recomputed.
// A stalled result word holds the sequencer.
module bitmap_allocator_find_free_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bmalloc_pkg::CMD_W-1:0]       s_cmd,
    input  logic [bmalloc_pkg::ITEM_W-1:0]      s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bmalloc_pkg::STATUS_W-1:0]    m_status,
    output logic                                m_bit_value,
    output logic [bmalloc_pkg::ITEM_W-1:0]      m_free_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmalloc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmalloc_pkg::ITEM_W-1:0]      cfg_data
);
    import bmalloc_pkg::*;

    logic [ITEM_W-1:0] low_item_reg, low_item_next;
    logic [ITEM_W-1:0] high_item_reg, high_item_next;
    logic              cfg_we;
    range_info_t       rinfo;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb begin
        low_item_next  = low_item_reg;
        high_item_next = high_item_reg;
        if (cfg_we) begin
            if (cfg_index == CFG_LOW_ITEM) begin
                low_item_next = cfg_data;
            end
            if (cfg_index == CFG_HIGH_ITEM) begin
                high_item_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_item_reg  <= LOW_ITEM_RESET;
            high_item_reg <= HIGH_ITEM_RESET;
        end else begin
            low_item_reg  <= low_item_next;
            high_item_reg <= high_item_next;
        end
    end

    bmalloc_range u_range (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .low_item  (low_item_reg),
        .high_item (high_item_reg),
        .rinfo     (rinfo)
    );

    bmalloc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rinfo       (rinfo),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_bit_value (m_bit_value),
        .m_free_item (m_free_item)
    );

endmodule
